// File: design/motor_speed_pi_with_slew_unit_assert.svh
// Assertion macros for the motor speed PI unit.
// Included by the top level; expects clk and rst_n in scope.
`ifndef MOTOR_SPEED_PI_WITH_SLEW_UNIT_ASSERT_SVH
`define MOTOR_SPEED_PI_WITH_SLEW_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MSPS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define MSPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MSPS_ASSERT_IMPL(lbl, ante, cons, msg)
`define MSPS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: design/msps_pkg.sv
// Shared constants, register codes and request types of the motor speed PI unit.
// No dependencies.
`default_nettype none
package msps_pkg;
  localparam int WINDOW_LEN_DEF        = 10;
  localparam int CONTROL_PERIOD_MS_DEF = 100;
  localparam int MAX_GAP_MS_DEF        = 100;

  localparam int DRIVE_LIMIT = 65280;
  localparam int SPEED_SCALE = 4000;
  localparam int MS_PER_S    = 1000;
  localparam int DU_SHIFT    = 20;

  // ms-to-s scaling: 1000 = 8 * 125 and 256 / 1000 = 32 / 125; divide by 125
  // through a reciprocal that is exact for operands below 2^31
  localparam int          GAIN_PRESHIFT = 3;
  localparam int          SLEW_NUM      = 32;
  localparam int          SCL_W         = 31;
  localparam logic [31:0] RECIP125      = 32'd2199023256;
  localparam int          RECIP125_SH   = 38;

  localparam int DIV_W = 40;
  localparam int DVS_W = 16;
  localparam int MA_W  = 33;
  localparam int MB_W  = 25;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOOT_DRIVE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOOT_DUR   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SLEW       = 3'd5;

  localparam logic signed [20:0] TARGET_RST     = 21'sd600;
  localparam logic [23:0]        PROP_GAIN_RST  = 24'd234881;
  localparam logic [23:0]        INTEG_GAIN_RST = 24'd15099;
  localparam logic [7:0]         BOOT_DRIVE_RST = 8'd20;
  localparam logic [15:0]        BOOT_DUR_RST   = 16'd200;
  localparam logic [15:0]        SLEW_RST       = 16'd800;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            start;
    logic [MA_W-1:0] a;
    logic [MB_W-1:0] b;
  } mul_req_t;
endpackage
`default_nettype wire

// File: design/motor_speed_pi_with_slew_unit.sv
// One motor channel: windowed speed estimate plus incremental PI with slew limit.
// Top level; depends on msps_pkg, msps_ram, msps_div, msps_mul and the assert header.
//
// Usage:
//  - Input channel (in_valid/in_stall): opcode 0 is a speed sample (count delta
//    and window in ms), opcode 1 is a control tick. One beat per item.
//  - Result channel (out_valid/out_stall): one beat per item carrying duty,
//    direction, averaged speed and the boot flag after that item.
//  - Config channel (cfg_valid/cfg_ready): always ready; write only while idle.
//  - A sample runs a speed divide, then an average divide, on the one shared
//    divider; a closed-loop tick works out the gain and slew terms (ST_GAIN,
//    ST_SLEW), then runs the shift-add multiply. Gap, zero-window and boot
//    items go straight from acceptance to the output state.
//  - One item is in flight at a time; in_stall stays high until its result is
//    loaded into the output register.
//  - Reset loads register defaults, clears the speed window bookkeeping, sets
//    the boot timer from the boot duration and the drive to boot_drive*256.
//    The window RAM is not cleared: the fill count masks stale entries.
//  - A stalled result holds in the output register; the next item is taken,
//    but its result waits until the held beat leaves.
`default_nettype none
`include "motor_speed_pi_with_slew_unit_assert.svh"
module motor_speed_pi_with_slew_unit #(
  parameter int WINDOW_LEN        = msps_pkg::WINDOW_LEN_DEF,
  parameter int CONTROL_PERIOD_MS = msps_pkg::CONTROL_PERIOD_MS_DEF,
  parameter int MAX_GAP_MS        = msps_pkg::MAX_GAP_MS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              in_opcode,
  input  wire logic signed [15:0]                in_count_delta,
  input  wire logic [15:0]                       in_window_ms,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [7:0]                             out_duty,
  output logic                                   out_forward,
  output logic signed [31:0]                     out_speed_avg,
  output logic                                   out_boot_active,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [msps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [msps_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import msps_pkg::*;

  localparam int PW    = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int FW    = $clog2(WINDOW_LEN + 1);
  localparam int SUM_W = 33 + PW;
  localparam int PRW   = MA_W + MB_W;
  localparam int CW    = 40;
  localparam int RCP_W = SCL_W + 32;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SPD  = 4'd1;
  localparam logic [3:0] ST_AVG  = 4'd2;
  localparam logic [3:0] ST_GAIN = 4'd3;
  localparam logic [3:0] ST_SLEW = 4'd4;
  localparam logic [3:0] ST_MUL  = 4'd5;
  localparam logic [3:0] ST_OUT  = 4'd6;

  localparam logic signed [CW-1:0] LIM_HI = CW'(DRIVE_LIMIT);
  localparam logic signed [CW-1:0] LIM_LO = -CW'(DRIVE_LIMIT);
  localparam logic signed [16:0]   DRV_HI = 17'(DRIVE_LIMIT);
  localparam logic signed [16:0]   DRV_LO = -17'(DRIVE_LIMIT);

  // configuration
  logic signed [20:0] target_r;
  logic [23:0]        kp_r, ki_r;
  logic [7:0]         boot_drv_r;
  logic [15:0]        slew_r;

  // channel state
  logic [3:0]               state_r, state_nxt;
  logic [PW-1:0]            pos_r, pos_nxt;
  logic [FW-1:0]            fill_r, fill_nxt;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic signed [31:0]       avg_r, avg_nxt;
  logic signed [16:0]       drive_r, drive_nxt;
  logic                     in_boot_r, in_boot_nxt;
  logic [15:0]              boot_rem_r, boot_rem_nxt;
  logic                     neg_r, neg_nxt;
  logic [MB_W-1:0]          gain_r, gain_nxt, smax_r, smax_nxt;
  logic [SCL_W-1:0]         scl_r, scl_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         duty_r, duty_nxt;
  logic               fwd_r, fwd_nxt;
  logic signed [31:0] spd_r, spd_nxt;
  logic               boot_o_r, boot_o_nxt;

  // datapath units
  div_req_t           div_req;
  logic               div_done;
  logic [DIV_W-1:0]   div_q;
  mul_req_t           mul_req;
  logic               mul_done;
  logic [PRW-1:0]     mul_p;
  logic               ram_we;
  logic signed [31:0] ram_wdata, ram_rdata;

  // combinational helpers
  logic                    in_acc;
  logic [16:0]             delta_mag;
  logic signed [31:0]      speed_s, old_s;
  logic signed [SUM_W-1:0] sum_new;
  logic [SUM_W-1:0]        sum_mag;
  logic signed [33:0]      err_s;
  logic [33:0]             err_mag;
  logic [PRW-DU_SHIFT-1:0] du_mag;
  logic signed [CW-1:0]    du_s, cmd_s, hi_s, lo_s;
  logic [16:0]             drv_mag;
  logic [17:0]             duty_sum;
  logic [RCP_W-1:0]        rcp_p;
  logic [MB_W-1:0]         rcp_q;

  msps_ram #(.WIDTH(32), .DEPTH(WINDOW_LEN)) u_win_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pos_r),
    .wdata (ram_wdata),
    .raddr (pos_r),
    .rdata (ram_rdata)
  );

  msps_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quot  (div_q)
  );

  msps_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .done  (mul_done),
    .prod  (mul_p)
  );

  assign in_acc = in_valid && !in_stall;

  always_comb begin
    state_nxt    = state_r;
    pos_nxt      = pos_r;
    fill_nxt     = fill_r;
    sum_nxt      = sum_r;
    avg_nxt      = avg_r;
    drive_nxt    = drive_r;
    in_boot_nxt  = in_boot_r;
    boot_rem_nxt = boot_rem_r;
    neg_nxt      = neg_r;
    gain_nxt     = gain_r;
    smax_nxt     = smax_r;
    scl_nxt      = scl_r;
    out_valid_nxt = out_valid_r && out_stall;
    duty_nxt     = duty_r;
    fwd_nxt      = fwd_r;
    spd_nxt      = spd_r;
    boot_o_nxt   = boot_o_r;
    div_req      = '0;
    mul_req      = '0;
    ram_we       = 1'b0;

    delta_mag = in_count_delta[15] ? 17'(-{in_count_delta[15], in_count_delta})
                                   : 17'({1'b0, in_count_delta});
    speed_s   = neg_r ? -$signed(div_q[31:0]) : $signed(div_q[31:0]);
    ram_wdata = speed_s;
    // entry at the write slot only counts once the window is full
    old_s     = (fill_r == FW'(WINDOW_LEN)) ? ram_rdata : 32'sd0;
    sum_new   = sum_r - SUM_W'(old_s) + SUM_W'(speed_s);
    sum_mag   = sum_new[SUM_W-1] ? SUM_W'(-sum_new) : SUM_W'(sum_new);
    err_s     = (34'(target_r) <<< 4) - 34'(avg_r);
    err_mag   = err_s[33] ? 34'(-err_s) : 34'(err_s);
    du_mag    = mul_p[PRW-1:DU_SHIFT];
    du_s      = neg_r ? -CW'(du_mag) : CW'(du_mag);
    cmd_s     = CW'(drive_r) + du_s;
    hi_s      = CW'(drive_r) + CW'(smax_r);
    lo_s      = CW'(drive_r) - CW'(smax_r);
    drv_mag   = drive_r[16] ? 17'(-drive_r) : 17'(drive_r);
    duty_sum  = 18'(drv_mag) + 18'd128;
    // divide the staged operand by 125
    rcp_p     = RCP_W'(scl_r) * RCP_W'(RECIP125);
    rcp_q     = rcp_p[RECIP125_SH +: MB_W];

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (!in_opcode) begin
            // boot timer counts all sampled time, gaps included
            boot_rem_nxt = (boot_rem_r > in_window_ms) ? boot_rem_r - in_window_ms : 16'd0;
            if (in_window_ms > 16'(MAX_GAP_MS)) begin
              pos_nxt   = '0;
              fill_nxt  = '0;
              sum_nxt   = '0;
              avg_nxt   = '0;
              state_nxt = ST_OUT;
            end else if (in_window_ms == 16'd0) begin
              state_nxt = ST_OUT;
            end else begin
              div_req.start    = 1'b1;
              div_req.dividend = DIV_W'(delta_mag) * DIV_W'(SPEED_SCALE);
              div_req.divisor  = in_window_ms;
              neg_nxt          = in_count_delta[15];
              state_nxt        = ST_SPD;
            end
          end else if (in_boot_r && (boot_rem_r != 16'd0)) begin
            drive_nxt = 17'({boot_drv_r, 8'd0});
            state_nxt = ST_OUT;
          end else begin
            // integral term per period: ki * period / 8, then / 125
            in_boot_nxt = 1'b0;
            scl_nxt     = SCL_W'((34'(ki_r) * 34'(CONTROL_PERIOD_MS)) >> GAIN_PRESHIFT);
            state_nxt   = ST_GAIN;
          end
        end
      end
      ST_SPD: begin
        if (div_done) begin
          // write the new speed, update running sum, advance the slot
          ram_we   = 1'b1;
          sum_nxt  = sum_new;
          pos_nxt  = (pos_r == PW'(WINDOW_LEN - 1)) ? '0 : pos_r + 1'b1;
          fill_nxt = (fill_r == FW'(WINDOW_LEN)) ? fill_r : fill_r + 1'b1;
          div_req.start    = 1'b1;
          div_req.dividend = DIV_W'(sum_mag);
          div_req.divisor  = DVS_W'(fill_nxt);
          neg_nxt          = sum_new[SUM_W-1];
          state_nxt        = ST_AVG;
        end
      end
      ST_AVG: begin
        if (div_done) begin
          avg_nxt   = speed_s;
          state_nxt = ST_OUT;
        end
      end
      ST_GAIN: begin
        // slew step per period in Q8.8: slew * period * 32, then / 125
        gain_nxt  = MB_W'(kp_r) + rcp_q;
        scl_nxt   = SCL_W'(32'(slew_r) * 32'(CONTROL_PERIOD_MS * SLEW_NUM));
        state_nxt = ST_SLEW;
      end
      ST_SLEW: begin
        smax_nxt      = rcp_q;
        mul_req.start = 1'b1;
        mul_req.a     = err_mag[MA_W-1:0];
        mul_req.b     = gain_r;
        neg_nxt       = err_s[33];
        state_nxt     = ST_MUL;
      end
      ST_MUL: begin
        if (mul_done) begin
          // clamp to full scale, then to the slew band around the last drive
          if (cmd_s > LIM_HI) cmd_s = LIM_HI;
          if (cmd_s < LIM_LO) cmd_s = LIM_LO;
          if (cmd_s > hi_s) cmd_s = hi_s;
          if (cmd_s < lo_s) cmd_s = lo_s;
          drive_nxt = cmd_s[16:0];
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          duty_nxt      = duty_sum[15:8];
          fwd_nxt       = !drive_r[16];
          spd_nxt       = avg_r;
          boot_o_nxt    = in_boot_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r    <= TARGET_RST;
      kp_r        <= PROP_GAIN_RST;
      ki_r        <= INTEG_GAIN_RST;
      boot_drv_r  <= BOOT_DRIVE_RST;
      slew_r      <= SLEW_RST;
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
      avg_r       <= '0;
      drive_r     <= 17'({BOOT_DRIVE_RST, 8'd0});
      in_boot_r   <= 1'b1;
      boot_rem_r  <= BOOT_DUR_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TARGET:     target_r   <= cfg_wdata[20:0];
          REG_PROP_GAIN:  kp_r       <= cfg_wdata;
          REG_INTEG_GAIN: ki_r       <= cfg_wdata;
          REG_BOOT_DRIVE: boot_drv_r <= cfg_wdata[7:0];
          // boot duration only seeds the timer at reset; drop the write
          REG_BOOT_DUR:   ;
          REG_SLEW:       slew_r     <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      fill_r      <= fill_nxt;
      sum_r       <= sum_nxt;
      avg_r       <= avg_nxt;
      drive_r     <= drive_nxt;
      in_boot_r   <= in_boot_nxt;
      boot_rem_r  <= boot_rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
    neg_r    <= neg_nxt;
    gain_r   <= gain_nxt;
    smax_r   <= smax_nxt;
    scl_r    <= scl_nxt;
    duty_r   <= duty_nxt;
    fwd_r    <= fwd_nxt;
    spd_r    <= spd_nxt;
    boot_o_r <= boot_o_nxt;
  end

  assign in_stall        = (state_r != ST_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_duty        = duty_r;
  assign out_forward     = fwd_r;
  assign out_speed_avg   = spd_r;
  assign out_boot_active = boot_o_r;

  `MSPS_ASSERT_NEXT(a_busy_after_accept, in_acc, in_stall, "item accepted but input not stalled")
  `MSPS_ASSERT_IMPL(a_fill_bound, 1'b1, fill_r <= FW'(WINDOW_LEN), "window fill beyond length")
  `MSPS_ASSERT_IMPL(a_drive_bound, !in_boot_r, (drive_r <= DRV_HI) && (drive_r >= DRV_LO), "drive out of range")
  `MSPS_ASSERT_IMPL(a_boot_clear_in_loop, state_r == ST_GAIN, !in_boot_r, "boot flag set in closed-loop step")
endmodule
`default_nettype wire

// File: design/msps_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module msps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 10
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: design/msps_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on msps_pkg.
`default_nettype none
module msps_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire msps_pkg::div_req_t req,
  output logic                   done,
  output logic [msps_pkg::DIV_W-1:0] quot
);
  import msps_pkg::*;
  localparam int CW = $clog2(DIV_W);

  logic             busy_r, busy_nxt, done_r, done_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt, dvs_r, dvs_nxt;
  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [DVS_W:0]   trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    trial    = {rem_r, quo_r[DIV_W-1]};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(DIV_W - 1);
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      quo_nxt  = req.dividend;
    end else if (busy_r) begin
      // shift in one dividend bit, subtract when it fits
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = DVS_W'(trial - {1'b0, dvs_r});
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DVS_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quot = quo_r;
endmodule
`default_nettype wire

// File: design/msps_mul.sv
// Shift-add unsigned multiplier, one multiplier bit per cycle.
// Depends on msps_pkg.
`default_nettype none
module msps_mul (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire msps_pkg::mul_req_t req,
  output logic                   done,
  output logic [msps_pkg::MA_W+msps_pkg::MB_W-1:0] prod
);
  import msps_pkg::*;
  localparam int PW = MA_W + MB_W;
  localparam int CW = $clog2(MB_W);

  logic            busy_r, busy_nxt, done_r, done_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [PW-1:0]   acc_r, acc_nxt, ash_r, ash_nxt;
  logic [MB_W-1:0] b_r, b_nxt;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    ash_nxt  = ash_r;
    b_nxt    = b_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(MB_W - 1);
      acc_nxt  = '0;
      ash_nxt  = PW'(req.a);
      b_nxt    = req.b;
    end else if (busy_r) begin
      if (b_r[0]) begin
        acc_nxt = acc_r + ash_r;
      end
      ash_nxt = {ash_r[PW-2:0], 1'b0};
      b_nxt   = {1'b0, b_r[MB_W-1:1]};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    ash_r <= ash_nxt;
    b_r   <= b_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;
endmodule
`default_nettype wire

// File: test/msps_checker.sv
// Result checker for motor_speed_pi_with_slew_unit: watches the config, input
// and result channels, predicts each result beat and compares it field by field.
// Depends on msps_pkg.
`timescale 1ns / 1ps
module msps_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic                                in_opcode,
  input  logic signed [15:0]                  in_count_delta,
  input  logic [15:0]                         in_window_ms,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic [7:0]                          out_duty,
  input  logic                                out_forward,
  input  logic signed [31:0]                  out_speed_avg,
  input  logic                                out_boot_active,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [msps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [msps_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output int                                  mismatches,
  output int                                  beats_owed
);
  import msps_pkg::*;

  localparam int NWIN = WINDOW_LEN_DEF;

  typedef struct packed {
    logic [7:0]         duty;
    logic               forward;
    logic signed [31:0] speed_avg;
    logic               boot_active;
  } drive_beat_t;

  drive_beat_t owed_beats[$];

  // Register copies
  logic signed [20:0] tgt;
  logic [23:0]        kp, ki;
  logic [7:0]         boot_lvl;
  logic [15:0]        slew;
  // Channel state
  logic signed [31:0] speeds[NWIN];
  int                 wpos, fill;
  logic signed [31:0] avg_speed;
  longint             drive;
  logic               booting;
  longint             boot_left;

  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  task automatic advance_channel(logic op, logic signed [15:0] delta, logic [15:0] wms,
                                 output drive_beat_t b);
    longint sum, e, g, du, cmd, smax, mag;
    if (!op) begin
      boot_left = (boot_left > wms) ? boot_left - wms : 0;
      if (wms > MAX_GAP_MS_DEF) begin
        foreach (speeds[i]) speeds[i] = '0;
        wpos = 0;
        fill = 0;
        avg_speed = '0;
      end else if (wms != 0) begin
        speeds[wpos] = clip32((longint'(delta) * SPEED_SCALE) / longint'(wms));
        wpos = (wpos + 1) % NWIN;
        if (fill < NWIN) fill++;
        sum = 0;
        for (int i = 0; i < fill; i++) sum += speeds[i];
        avg_speed = clip32(sum / fill);
      end
    end else begin
      if (booting && boot_left != 0) begin
        drive = longint'(boot_lvl) * 256;
      end else begin
        booting = 1'b0;
        e = longint'(tgt) * 16 - longint'(avg_speed);
        g = longint'(kp) + (longint'(ki) * CONTROL_PERIOD_MS_DEF) / MS_PER_S;
        du = (e * g) / (64'sd1 <<< DU_SHIFT);
        cmd = drive + du;
        if (cmd > DRIVE_LIMIT) cmd = DRIVE_LIMIT;
        if (cmd < -DRIVE_LIMIT) cmd = -DRIVE_LIMIT;
        smax = (longint'(slew) * CONTROL_PERIOD_MS_DEF * 256) / MS_PER_S;
        if (cmd > drive + smax) cmd = drive + smax;
        if (cmd < drive - smax) cmd = drive - smax;
        drive = cmd;
      end
    end
    mag = (drive < 0) ? -drive : drive;
    b.duty = 8'((mag + 128) >>> 8);
    b.forward = (drive >= 0);
    b.speed_avg = avg_speed;
    b.boot_active = booting;
  endtask

  always @(posedge clk) begin
    drive_beat_t want, got;
    if (!rst_n) begin
      tgt = TARGET_RST;
      kp = PROP_GAIN_RST;
      ki = INTEG_GAIN_RST;
      boot_lvl = BOOT_DRIVE_RST;
      slew = SLEW_RST;
      foreach (speeds[i]) speeds[i] = '0;
      wpos = 0;
      fill = 0;
      avg_speed = '0;
      drive = longint'(BOOT_DRIVE_RST) * 256;
      booting = 1'b1;
      boot_left = BOOT_DUR_RST;
      owed_beats.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TARGET:     tgt = cfg_wdata[20:0];
          REG_PROP_GAIN:  kp = cfg_wdata;
          REG_INTEG_GAIN: ki = cfg_wdata;
          REG_BOOT_DRIVE: boot_lvl = cfg_wdata[7:0];
          // boot duration only matters at reset
          REG_BOOT_DUR:   ;
          REG_SLEW:       slew = cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        advance_channel(in_opcode, in_count_delta, in_window_ms, want);
        owed_beats.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (owed_beats.size() == 0) begin
          report("unexpected result beat", 1, 0);
        end else begin
          want = owed_beats.pop_front();
          got = '{out_duty, out_forward, out_speed_avg, out_boot_active};
          if (got.duty !== want.duty) report("duty", got.duty, want.duty);
          if (got.forward !== want.forward) report("forward", got.forward, want.forward);
          if (got.speed_avg !== want.speed_avg)
            report("speed_avg", got.speed_avg, want.speed_avg);
          if (got.boot_active !== want.boot_active)
            report("boot_active", got.boot_active, want.boot_active);
        end
      end
    end
    beats_owed = owed_beats.size();
  end
endmodule

// File: test/tb_motor_speed_pi_with_slew_unit.sv
// Testbench top for motor_speed_pi_with_slew_unit: clock, reset, stimulus and
// verdict. Depends on msps_pkg, msps_checker and the block's RTL.
`timescale 1ns / 1ps
module tb_motor_speed_pi_with_slew_unit;
  import msps_pkg::*;

  localparam longint CYCLE_LIMIT = 3000000;
  localparam int     SETTLE      = 160;  // well over the slowest item latency

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_opcode = 1'b0;
  logic signed [15:0] in_count_delta = '0;
  logic [15:0] in_window_ms = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic [7:0] out_duty;
  logic out_forward;
  logic signed [31:0] out_speed_avg;
  logic out_boot_active;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int mismatches, beats_owed;
  int hold_cycles;
  bit steady;          // when set, neither side idles
  longint cycles = 0;

  motor_speed_pi_with_slew_unit dut (.*);

  msps_checker chk (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  // Hold reset low from the start, release at a falling edge.
  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // Result side: after each beat draw how long to stall before the next one.
  always @(posedge clk) begin
    if (!rst_n)
      hold_cycles <= 0;
    else if (out_valid && !out_stall)
      hold_cycles <= steady ? 0 : $urandom_range(0, 7);
    else if (hold_cycles != 0)
      hold_cycles <= hold_cycles - 1;
  end

  always @(negedge clk) out_stall <= rst_n ? (hold_cycles != 0) : 1'b1;

  // Watchdog: end the run if the block hangs.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Send one input beat; drop valid only when there is an idle gap.
  task automatic send_item(logic op, logic signed [15:0] delta, logic [15:0] wms);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_opcode <= op;
    in_count_delta <= delta;
    in_window_ms <= wms;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic sample(logic signed [15:0] delta, logic [15:0] wms);
    send_item(1'b0, delta, wms);
  endtask

  task automatic tick();
    send_item(1'b1, 16'($urandom), 16'($urandom));
  endtask

  // Drain the block, then let any result-free work finish before a write.
  task automatic quiesce();
    in_valid <= 1'b0;
    while (beats_owed != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_wdata <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_settings(logic [20:0] tgt, logic [23:0] kp, logic [23:0] ki,
                               logic [7:0] lvl, logic [15:0] blen, logic [15:0] slw);
    quiesce();
    write_reg(REG_TARGET, 24'(tgt));
    write_reg(REG_PROP_GAIN, kp);
    write_reg(REG_INTEG_GAIN, ki);
    write_reg(REG_BOOT_DRIVE, 24'(lvl));
    write_reg(REG_BOOT_DUR, 24'(blen));
    write_reg(REG_SLEW, 24'(slw));
  endtask

  // Random mix: mostly valid samples and ticks, some gaps and empty windows.
  task automatic random_items(int n);
    int pick;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 22)
        tick();
      else if (pick < 27)
        sample(16'($urandom), 16'($urandom_range(101, 65535)));
      else if (pick < 30)
        sample(16'($urandom), 16'd0);
      else if (pick < 40)
        sample(16'($urandom), 16'($urandom_range(1, 100)));
      else
        sample(16'($urandom_range(0, 600) - 300), 16'($urandom_range(5, 20)));
    end
  endtask

  initial begin
    steady = 1'b0;
    @(posedge rst_n);
    @(negedge clk);

    // Directed: boot ticks, window edges, field extremes and the boot exit.
    tick();                              // boot tick at default level
    quiesce();
    write_reg(REG_BOOT_DRIVE, 24'd255);
    tick();
    sample(16'sd100, 16'd150);           // gap in boot; timer down to 50
    tick();
    sample(16'sd5, 16'd0);               // empty window
    sample(16'sd32767, 16'd1);
    sample(16'sh8000, 16'd100);
    sample(16'sh8000, 16'd1);
    sample(16'sd1234, 16'd101);          // just over the gap limit
    sample(16'sd40, 16'd10);
    tick();                              // timer hit zero: boot ends here
    tick();
    sample(16'sd0, 16'd65535);
    for (int k = 0; k < 11; k++) sample(16'(60 + k), 16'd10);  // wrap the window
    tick();
    tick();

    // Settings sweep, extremes included; each phase ends with a drain.
    load_settings(21'h100000, 24'd0, 24'd0, 8'd0, 16'd0, 16'd0);
    random_items(120);
    load_settings(21'h0fffff, 24'hffffff, 24'hffffff, 8'hff, 16'hffff, 16'hffff);
    random_items(150);
    load_settings(21'h100000, 24'hffffff, 24'hffffff, 8'd7, 16'd1, 16'hffff);
    random_items(150);
    steady = 1'b1;
    load_settings(21'd600, 24'd234881, 24'd15099, 8'd20, 16'd200, 16'd800);
    random_items(150);
    steady = 1'b0;
    for (int ph = 0; ph < 4; ph++) begin
      load_settings(21'($urandom_range(0, 4000) - 2000),
                    24'($urandom >> $urandom_range(0, 20)),
                    24'($urandom >> $urandom_range(0, 20)), 8'($urandom), 16'($urandom),
                    16'($urandom_range(0, 3000)));
      steady = (ph == 2);
      random_items(170);
    end

    in_valid <= 1'b0;
    while (beats_owed != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule
